// ----- sv/quaternion_multiply_normalize_core_macros.svh -----
// assertion macros for the quaternion multiply normalize core
`ifndef QUATERNION_MULTIPLY_NORMALIZE_CORE_MACROS_SVH
`define QUATERNION_MULTIPLY_NORMALIZE_CORE_MACROS_SVH

// same-cycle implication, off during reset
`define QMN_ASSERT_HOLDS(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (expr)) \
        else $error("qmn assertion failed");

// next-cycle implication, checked during reset too
`define QMN_ASSERT_NEXT(label, clk, cond, expr) \
    label: assert property (@(posedge clk) (cond) |=> (expr)) \
        else $error("qmn assertion failed");

`endif

// ----- sv/qmn_pkg.sv -----
// shared types and widths for the quaternion multiply normalize core
package qmn_pkg;
    localparam int COMP_W = 16;
    localparam int NCOMP  = 4;
    localparam int PROD_W = 34;
    localparam int MAG_W  = 33;
    localparam int SQ_W   = 66;
    localparam int SUM_W  = 68;
    localparam int ROOT_W = 35;
    localparam int REM_W  = 36;

    typedef logic signed [COMP_W-1:0] comp_t;
    typedef logic [MAG_W-1:0] mag_t;
    typedef logic [SUM_W-1:0] sum_t;
    typedef logic [ROOT_W-1:0] root_t;
    typedef logic [REM_W-1:0] rem_t;

    // component magnitudes and signs carried alongside the norm
    typedef struct packed {
        logic [NCOMP-1:0] neg;
        mag_t [NCOMP-1:0] mag;
    } qmn_comp_t;
endpackage

// ----- sv/quaternion_multiply_normalize_core.sv -----
// top level of the normalized quaternion product core
// path from input transaction to m_tvalid: product, root and divider pipelines, then the output buffer
// throughput: one transaction per cycle while s_tready is high, set by the 35-stage root and per-bit divider
// a two-entry output buffer keeps s_tready registered; stalls hold the whole pipeline
// synchronous active-low reset empties the pipeline and output buffer
`include "quaternion_multiply_normalize_core_macros.svh"
module quaternion_multiply_normalize_core #(
    parameter int FRAC_BITS = 14
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // first_w, first_x, first_y, first_z, second_w, second_x, second_y, second_z
    input  logic [127:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // prod_w, prod_x, prod_y, prod_z
    output logic [63:0]  m_tdata,
    // zero_norm
    output logic [0:0]   m_tuser
);
    import qmn_pkg::*;

    logic en;
    comp_t [7:0] comp_in;
    logic p_valid, r_valid, d_valid, d_zero;
    sum_t p_sum;
    qmn_comp_t p_comps, r_comps;
    root_t r_norm;
    comp_t [3:0] d_prod;

    logic out_v_reg, skid_v_reg;
    logic [63:0] out_data_reg, skid_data_reg;
    logic out_zero_reg, skid_zero_reg;
    logic push;

    assign en       = !skid_v_reg;
    assign s_tready = en;
    assign push     = en && d_valid;

    for (genvar gi = 0; gi < 8; gi++) begin : g_unpack
        assign comp_in[gi] = comp_t'(s_tdata[gi*16 +: 16]);
    end

    qmn_product u_product (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid && s_tready),
        .comp      (comp_in),
        .out_valid (p_valid),
        .sum       (p_sum),
        .comps     (p_comps)
    );

    qmn_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (p_valid),
        .sum       (p_sum),
        .in_comps  (p_comps),
        .out_valid (r_valid),
        .norm      (r_norm),
        .out_comps (r_comps)
    );

    qmn_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (r_valid),
        .norm      (r_norm),
        .comps     (r_comps),
        .out_valid (d_valid),
        .prod      (d_prod),
        .zero_norm (d_zero)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end else if (skid_v_reg) begin
            if (!out_v_reg || m_tready) begin
                out_v_reg  <= 1'b1;
                skid_v_reg <= 1'b0;
            end
        end else if (push) begin
            if (out_v_reg && !m_tready) skid_v_reg <= 1'b1;
            else                        out_v_reg  <= 1'b1;
        end else if (m_tready) begin
            out_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_v_reg) begin
            if (!out_v_reg || m_tready) begin
                out_data_reg <= skid_data_reg;
                out_zero_reg <= skid_zero_reg;
            end
        end else if (push) begin
            if (out_v_reg && !m_tready) begin
                skid_data_reg <= d_prod;
                skid_zero_reg <= d_zero;
            end else begin
                out_data_reg <= d_prod;
                out_zero_reg <= d_zero;
            end
        end
    end

    assign m_tvalid   = out_v_reg;
    assign m_tdata    = out_data_reg;
    assign m_tuser[0] = out_zero_reg;

    `QMN_ASSERT_HOLDS(a_zero_norm_clears, aclk, aresetn, m_tvalid && m_tuser[0], m_tdata == '0)
    `QMN_ASSERT_HOLDS(a_skid_behind_out, aclk, aresetn, skid_v_reg, out_v_reg)
    `QMN_ASSERT_NEXT(a_reset_empties, aclk, !aresetn, !m_tvalid && s_tready)
endmodule

// ----- sv/qmn_product.sv -----
// hamilton product, magnitudes and exact sum of squares, six stages
module qmn_product (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         en,
    input  logic                         in_valid,
    input  qmn_pkg::comp_t [7:0]         comp,
    output logic                         out_valid,
    output qmn_pkg::sum_t                sum,
    output qmn_pkg::qmn_comp_t           comps
);
    import qmn_pkg::*;

    // subtract mask per product component, indexed by term
    localparam logic [3:0] SUB_MASK [NCOMP] = '{4'b1110, 4'b1000, 4'b0010, 4'b0100};

    logic [6:1] v_reg;
    logic signed [31:0] term_reg [NCOMP][NCOMP];
    logic signed [PROD_W-1:0] p_next [NCOMP];
    qmn_comp_t c2_next;
    qmn_comp_t c_reg [2:6];
    logic [31:0] hh_reg [NCOMP];
    logic [32:0] hl_reg [NCOMP];
    logic [33:0] ll_reg [NCOMP];
    logic [SQ_W-1:0] sq_reg [NCOMP];
    logic [SUM_W-2:0] s01_reg, s23_reg;
    sum_t sum_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[5:1], in_valid};
        end
    end

    // stage 1: sixteen products, second operand index is first index xor k
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < NCOMP; k++) begin
                for (int i = 0; i < NCOMP; i++) begin
                    term_reg[k][i] <= 32'(comp[i] * comp[4 + (i ^ k)]);
                end
            end
        end
    end

    // stage 2: signed sums and magnitudes
    always_comb begin
        for (int k = 0; k < NCOMP; k++) begin
            p_next[k] = '0;
            for (int i = 0; i < NCOMP; i++) begin
                if (SUB_MASK[k][i]) p_next[k] = p_next[k] - PROD_W'(term_reg[k][i]);
                else                p_next[k] = p_next[k] + PROD_W'(term_reg[k][i]);
            end
            c2_next.neg[k] = p_next[k][PROD_W-1];
            c2_next.mag[k] = p_next[k][PROD_W-1] ? MAG_W'(-p_next[k]) : MAG_W'(p_next[k]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c_reg[2] <= c2_next;
            c_reg[3] <= c_reg[2];
            c_reg[4] <= c_reg[3];
            c_reg[5] <= c_reg[4];
            c_reg[6] <= c_reg[5];
            // stage 3: partial squares
            for (int k = 0; k < NCOMP; k++) begin
                hh_reg[k] <= c_reg[2].mag[k][32:17] * c_reg[2].mag[k][32:17];
                hl_reg[k] <= 33'(c_reg[2].mag[k][32:17] * c_reg[2].mag[k][16:0]);
                ll_reg[k] <= 34'(c_reg[2].mag[k][16:0] * c_reg[2].mag[k][16:0]);
            end
            // stage 4: full squares
            for (int k = 0; k < NCOMP; k++) begin
                sq_reg[k] <= {hh_reg[k], 34'd0} + {15'd0, hl_reg[k], 18'd0}
                    + {32'd0, ll_reg[k]};
            end
            // stages 5 and 6: adder tree
            s01_reg <= (SUM_W-1)'(sq_reg[0]) + (SUM_W-1)'(sq_reg[1]);
            s23_reg <= (SUM_W-1)'(sq_reg[2]) + (SUM_W-1)'(sq_reg[3]);
            sum_reg <= SUM_W'(s01_reg) + SUM_W'(s23_reg);
        end
    end

    assign out_valid = v_reg[6];
    assign sum       = sum_reg;
    assign comps     = c_reg[6];
endmodule

// ----- sv/qmn_sqrt.sv -----
// pipelined integer square root, one root bit per stage
module qmn_sqrt (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_valid,
    input  qmn_pkg::sum_t        sum,
    input  qmn_pkg::qmn_comp_t   in_comps,
    output logic                 out_valid,
    output qmn_pkg::root_t       norm,
    output qmn_pkg::qmn_comp_t   out_comps
);
    import qmn_pkg::*;

    localparam int TRIAL_W = 2 * ROOT_W;

    logic [ROOT_W-1:0] v_reg;
    sum_t      rem_reg  [ROOT_W];
    root_t     root_reg [ROOT_W];
    qmn_comp_t c_reg    [ROOT_W];
    sum_t      rem_in   [ROOT_W];
    root_t     root_in  [ROOT_W];
    qmn_comp_t c_in     [ROOT_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[ROOT_W-2:0], in_valid};
        end
    end

    for (genvar gi = 0; gi < ROOT_W; gi++) begin : g_stage
        localparam int B = ROOT_W - 1 - gi;
        logic [TRIAL_W-1:0] trial;
        logic [TRIAL_W-1:0] rem_ext;
        logic take;

        if (gi == 0) begin : g_first
            assign rem_in[gi]  = sum;
            assign root_in[gi] = '0;
            assign c_in[gi]    = in_comps;
        end else begin : g_next
            assign rem_in[gi]  = rem_reg[gi-1];
            assign root_in[gi] = root_reg[gi-1];
            assign c_in[gi]    = c_reg[gi-1];
        end

        always_comb begin
            trial   = (TRIAL_W'(root_in[gi]) << (B + 1)) | (TRIAL_W'(1) << (2 * B));
            rem_ext = TRIAL_W'(rem_in[gi]);
            take    = rem_ext >= trial;
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[gi]  <= take ? SUM_W'(rem_ext - trial) : rem_in[gi];
                root_reg[gi] <= take ? (root_in[gi] | (ROOT_W'(1) << B)) : root_in[gi];
                c_reg[gi]    <= c_in[gi];
            end
        end
    end

    assign out_valid = v_reg[ROOT_W-1];
    assign norm      = root_reg[ROOT_W-1];
    assign out_comps = c_reg[ROOT_W-1];
endmodule

// ----- sv/qmn_div.sv -----
// pipelined restoring divider, four lanes, with saturation and zero-norm handling
module qmn_div #(
    parameter int FRAC_BITS = 14
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         en,
    input  logic                         in_valid,
    input  qmn_pkg::root_t               norm,
    input  qmn_pkg::qmn_comp_t           comps,
    output logic                         out_valid,
    output qmn_pkg::comp_t [3:0]         prod,
    output logic                         zero_norm
);
    import qmn_pkg::*;

    localparam int QW = FRAC_BITS + 1;
    localparam int CW = (QW > 17) ? QW : 17;

    logic [FRAC_BITS+1:0] v_reg;
    rem_t             r_reg    [FRAC_BITS+1][NCOMP];
    logic [QW-1:0]    q_reg    [FRAC_BITS+1][NCOMP];
    root_t            norm_reg [FRAC_BITS+1];
    logic [NCOMP-1:0] neg_reg  [FRAC_BITS+1];
    logic             zero_reg [FRAC_BITS+1];
    comp_t [3:0]      prod_reg;
    logic             zero_out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[FRAC_BITS:0], in_valid};
        end
    end

    // stage 0: top quotient bit, magnitude never exceeds the norm
    always_ff @(posedge aclk) begin
        if (en) begin
            norm_reg[0] <= norm;
            neg_reg[0]  <= comps.neg;
            zero_reg[0] <= norm == '0;
            for (int k = 0; k < NCOMP; k++) begin
                if (ROOT_W'(comps.mag[k]) >= norm) begin
                    r_reg[0][k] <= REM_W'(ROOT_W'(comps.mag[k]) - norm);
                    q_reg[0][k] <= QW'(1);
                end else begin
                    r_reg[0][k] <= REM_W'(comps.mag[k]);
                    q_reg[0][k] <= '0;
                end
            end
        end
    end

    for (genvar gj = 1; gj <= FRAC_BITS; gj++) begin : g_stage
        rem_t r2 [NCOMP];
        logic [NCOMP-1:0] ge;

        always_comb begin
            for (int k = 0; k < NCOMP; k++) begin
                r2[k] = {r_reg[gj-1][k][REM_W-2:0], 1'b0};
                ge[k] = r2[k] >= REM_W'(norm_reg[gj-1]);
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                norm_reg[gj] <= norm_reg[gj-1];
                neg_reg[gj]  <= neg_reg[gj-1];
                zero_reg[gj] <= zero_reg[gj-1];
                for (int k = 0; k < NCOMP; k++) begin
                    r_reg[gj][k] <= ge[k] ? r2[k] - REM_W'(norm_reg[gj-1]) : r2[k];
                    q_reg[gj][k] <= {q_reg[gj-1][k][QW-2:0], ge[k]};
                end
            end
        end
    end

    // final stage: sign, saturation, zero norm
    logic [CW-1:0] qx  [NCOMP];
    logic [CW-1:0] qn  [NCOMP];
    comp_t         res [NCOMP];

    always_comb begin
        for (int k = 0; k < NCOMP; k++) begin
            qx[k] = CW'(q_reg[FRAC_BITS][k]);
            qn[k] = CW'(0) - qx[k];
            if (zero_reg[FRAC_BITS]) begin
                res[k] = '0;
            end else if (neg_reg[FRAC_BITS][k]) begin
                res[k] = (qx[k] > CW'(32768)) ? 16'sh8000 : comp_t'(qn[k][15:0]);
            end else begin
                res[k] = (qx[k] > CW'(32767)) ? 16'sh7fff : comp_t'(qx[k][15:0]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < NCOMP; k++) prod_reg[k] <= res[k];
            zero_out_reg <= zero_reg[FRAC_BITS];
        end
    end

    assign out_valid = v_reg[FRAC_BITS+1];
    assign prod      = prod_reg;
    assign zero_norm = zero_out_reg;
endmodule
